// ===== rtl/pre_pkg.sv =====
// ----------------------------------------------------------------------------
// pre_pkg
// Shared types and constants for the printable run extractor: register map,
// reset values, result kinds and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package pre_pkg;

  // default for the longest held run
  localparam int MAX_MIN_LEN_DEF = 64;

  // register map, index taken from paddr[3:2]
  localparam logic [1:0] REG_MIN_LEN = 2'd0;
  localparam logic [1:0] REG_PARITY  = 2'd1;
  localparam logic [1:0] REG_BASE    = 2'd2;
  localparam logic [1:0] REG_LEN     = 2'd3;

  // register reset values
  localparam logic [6:0]  MIN_LEN_RST     = 7'd4;
  localparam logic        PARITY_RST      = 1'b0;
  localparam logic [31:0] REGION_BASE_RST = 32'h0000_0000;
  localparam logic [31:0] REGION_LEN_RST  = 32'hFFFF_FFFF;

  // printable test
  localparam logic [7:0] PARITY_MASK = 8'o200;
  localparam logic [7:0] PRINT_LO    = 8'h20;
  localparam logic [7:0] PRINT_HI    = 8'h7E;

  // result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // configuration view handed to the datapath
  typedef struct packed {
    logic [6:0]  min_length;
    logic        parity_ignore;
    logic        restart;     // region register written this cycle
    logic [31:0] base_val;    // region_base value after this cycle
    logic [31:0] len_val;     // region_length value after this cycle
  } pre_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input transaction this cycle
    logic rd_issue;  // read held byte at the burst index
    logic rd_load;   // move read byte into the output register
  } pre_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic burst_req; // the offered byte completes a run
    logic rd_last;   // burst index at the final held byte
    logic out_free;  // output register empty or being taken
  } pre_sts_t;

endpackage

// ===== rtl/pre_cfg.sv =====
// ----------------------------------------------------------------------------
// pre_cfg
// APB register file: min_length, parity_ignore, region_base, region_length.
// Writes to either region register restart the scan.
// ----------------------------------------------------------------------------
module pre_cfg
  import pre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output pre_cfg_t    cfg
);

  logic [6:0]  min_len_r, min_len_nxt;
  logic        parity_r, parity_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] len_r, len_nxt;
  logic        wr;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // write decode
  always_comb begin
    min_len_nxt = min_len_r;
    parity_nxt  = parity_r;
    base_nxt    = base_r;
    len_nxt     = len_r;
    if (wr) begin
      unique case (idx)
        REG_MIN_LEN: min_len_nxt = pwdata[6:0];
        REG_PARITY:  parity_nxt  = pwdata[0];
        REG_BASE:    base_nxt    = pwdata;
        REG_LEN:     len_nxt     = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RST;
      parity_r  <= PARITY_RST;
      base_r    <= REGION_BASE_RST;
      len_r     <= REGION_LEN_RST;
    end else begin
      min_len_r <= min_len_nxt;
      parity_r  <= parity_nxt;
      base_r    <= base_nxt;
      len_r     <= len_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_MIN_LEN: prdata = {25'd0, min_len_r};
      REG_PARITY:  prdata = {31'd0, parity_r};
      REG_BASE:    prdata = base_r;
      REG_LEN:     prdata = len_r;
      default:     prdata = 32'd0;
    endcase
  end

  // view for the datapath
  assign cfg.min_length    = min_len_r;
  assign cfg.parity_ignore = parity_r;
  assign cfg.restart       = wr && ((idx == REG_BASE) || (idx == REG_LEN));
  assign cfg.base_val      = base_nxt;
  assign cfg.len_val       = len_nxt;

endmodule

// ===== rtl/pre_dp.sv =====
// ----------------------------------------------------------------------------
// pre_dp
// Datapath: printable test, run buffer memory, run and region counters,
// start offset and the output register.
// ----------------------------------------------------------------------------
module pre_dp
  import pre_pkg::*;
#(
  parameter int MAX_MIN_LEN = MAX_MIN_LEN_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  pre_cfg_t    cfg,
  input  pre_cmd_t    cmd,
  output pre_sts_t    sts,
  input  logic [7:0]  in_data,
  input  logic        in_eof,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_char,
  output logic [31:0] out_offset,
  output logic        out_last
);

  localparam int CNT_W = $clog2(MAX_MIN_LEN + 1);
  localparam int IDX_W = (MAX_MIN_LEN > 1) ? $clog2(MAX_MIN_LEN) : 1;
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  // run buffer
  logic [7:0] run_mem [MAX_MIN_LEN];
  logic [7:0] rd_data_r;

  // control state
  logic [CNT_W-1:0] run_count_r, run_count_nxt;
  logic [CNT_W-1:0] burst_len_r, burst_len_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             emitting_r, emitting_nxt;
  logic             scan_done_r, scan_done_nxt;
  logic [31:0]      byte_pos_r, byte_pos_nxt;
  logic [31:0]      bytes_left_r, bytes_left_nxt;
  logic [31:0]      start_off_r, start_off_nxt;
  logic             out_vld_r, out_vld_nxt;

  // output payload
  logic             kind_r;
  logic [7:0]       char_r;
  logic [31:0]      offset_r;
  logic             last_r;

  logic [7:0]       test_byte;
  logic             printable;
  logic             live;
  logic             take_run;
  logic             load_single;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] eff_min;
  logic [CNT_W-1:0] rd_cnt_inc;

  // printable test, bit 7 optionally masked
  assign test_byte = in_data & ~(cfg.parity_ignore ? PARITY_MASK : 8'h00);
  assign printable = (test_byte >= PRINT_LO) && (test_byte <= PRINT_HI);

  // effective minimum run length, clamped to 1..MAX_MIN_LEN
  always_comb begin
    if (cfg.min_length == 7'd0) begin
      eff_min = CNT_W'(1);
    end else if (CMP_W'(cfg.min_length) > CMP_W'(MAX_MIN_LEN)) begin
      eff_min = CNT_W'(MAX_MIN_LEN);
    end else begin
      eff_min = CNT_W'(cfg.min_length);
    end
  end

  assign live        = !scan_done_r && !in_eof && (bytes_left_r != 32'd0);
  assign take_run    = live && !emitting_r && printable;
  assign cnt_inc     = run_count_r + CNT_W'(1);
  assign rd_cnt_inc  = CNT_W'(rd_idx_r) + CNT_W'(1);
  assign load_single = cmd.accept && live && emitting_r;

  assign sts.burst_req = take_run && (cnt_inc >= eff_min);
  assign sts.rd_last   = (rd_cnt_inc == burst_len_r);
  assign sts.out_free  = !out_vld_r || out_ready;

  // scan state update
  always_comb begin
    run_count_nxt  = run_count_r;
    burst_len_nxt  = burst_len_r;
    emitting_nxt   = emitting_r;
    scan_done_nxt  = scan_done_r;
    byte_pos_nxt   = byte_pos_r;
    bytes_left_nxt = bytes_left_r;
    start_off_nxt  = start_off_r;
    if (cfg.restart) begin
      run_count_nxt  = '0;
      emitting_nxt   = 1'b0;
      scan_done_nxt  = 1'b0;
      byte_pos_nxt   = cfg.base_val;
      bytes_left_nxt = cfg.len_val;
    end else if (cmd.accept && !scan_done_r) begin
      if (!live) begin
        scan_done_nxt = 1'b1;
      end else begin
        if (emitting_r) begin
          if (!printable) begin
            emitting_nxt = 1'b0;
          end
        end else if (printable) begin
          if (run_count_r == '0) begin
            start_off_nxt = byte_pos_r;
          end
          if (sts.burst_req) begin
            run_count_nxt = '0;
            burst_len_nxt = cnt_inc;
            emitting_nxt  = 1'b1;
          end else begin
            run_count_nxt = cnt_inc;
          end
        end else begin
          run_count_nxt = '0;
        end
        byte_pos_nxt   = byte_pos_r + 32'd1;
        bytes_left_nxt = bytes_left_r - 32'd1;
        if (bytes_left_r == 32'd1) begin
          scan_done_nxt = 1'b1;
        end
      end
    end
  end

  // burst read index
  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (cmd.accept && sts.burst_req) begin
      rd_idx_nxt = '0;
    end else if (cmd.rd_load && !sts.rd_last) begin
      rd_idx_nxt = IDX_W'(rd_cnt_inc);
    end
  end

  // output register valid
  always_comb begin
    out_vld_nxt = out_vld_r && !out_ready;
    if (load_single || cmd.rd_load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_count_r  <= '0;
      burst_len_r  <= '0;
      rd_idx_r     <= '0;
      emitting_r   <= 1'b0;
      scan_done_r  <= 1'b0;
      byte_pos_r   <= REGION_BASE_RST;
      bytes_left_r <= REGION_LEN_RST;
      start_off_r  <= 32'd0;
      out_vld_r    <= 1'b0;
    end else begin
      run_count_r  <= run_count_nxt;
      burst_len_r  <= burst_len_nxt;
      rd_idx_r     <= rd_idx_nxt;
      emitting_r   <= emitting_nxt;
      scan_done_r  <= scan_done_nxt;
      byte_pos_r   <= byte_pos_nxt;
      bytes_left_r <= bytes_left_nxt;
      start_off_r  <= start_off_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  // run buffer write and registered read
  always_ff @(posedge clk) begin
    if (cmd.accept && take_run) begin
      run_mem[run_count_r[IDX_W-1:0]] <= in_data;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= run_mem[rd_idx_r];
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load_single) begin
      kind_r   <= printable ? KIND_CHAR : KIND_END;
      char_r   <= printable ? in_data : 8'h00;
      offset_r <= start_off_r;
      last_r   <= 1'b1;
    end else if (cmd.rd_load) begin
      kind_r   <= KIND_CHAR;
      char_r   <= rd_data_r;
      offset_r <= start_off_r;
      last_r   <= sts.rd_last;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_kind   = kind_r;
  assign out_char   = char_r;
  assign out_offset = offset_r;
  assign out_last   = last_r;

endmodule

// ===== rtl/pre_ctrl.sv =====
// ----------------------------------------------------------------------------
// pre_ctrl
// Controller: takes input transactions and sequences the burst that
// releases the held bytes of a run, one read and one load per byte.
// ----------------------------------------------------------------------------
module pre_ctrl
  import pre_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pre_sts_t sts,
  output pre_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_LD   = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.rd_issue = 1'b0;
    cmd.rd_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid && in_ready;
        if (cmd.accept && sts.burst_req) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_LD;
      end
      S_LD: begin
        if (sts.out_free) begin
          cmd.rd_load = 1'b1;
          state_nxt   = sts.rd_last ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/printable_run_extractor.sv =====
// A pass-through byte or end marker is loaded straight into the output register.
// Throughput: one byte per cycle while no held run is being released and the output is taken.
// A run reaching min_length releases its N held bytes, one buffer
// read and one output load per byte, with input stalled meanwhile.
// Reset (synchronous, rst_n low) clears the scan and restores register defaults;
// the run buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// printable_run_extractor
// Scans a byte stream for runs of printable ASCII and emits each run of at
// least min_length bytes, tagged with its start offset, plus end markers.
// ----------------------------------------------------------------------------
module printable_run_extractor
  import pre_pkg::*;
#(
  parameter int MAX_MIN_LEN = MAX_MIN_LEN_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // end_of_file
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [7:0] out_char, [39:8] string_offset
  output logic        out_tuser,   // [0] out_kind
  output logic        out_tlast,   // last_of_burst
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  pre_cfg_t    cfg;
  pre_cmd_t    cmd;
  pre_sts_t    sts;
  logic [7:0]  res_char;
  logic [31:0] res_offset;

  // register file
  pre_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // controller
  pre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  pre_dp #(
    .MAX_MIN_LEN (MAX_MIN_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_data    (in_tdata),
    .in_eof     (in_tlast),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_char   (res_char),
    .out_offset (res_offset),
    .out_last   (out_tlast)
  );

  assign out_tdata = {res_offset, res_char};

endmodule

// ===== rtl/pre_chk.sv =====
// ----------------------------------------------------------------------------
// pre_chk
// Port-level checks for the printable run extractor, bound to the top level.
// ----------------------------------------------------------------------------
module pre_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast,
  input logic        cfg_pready
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // input is taken only when the output register frees up
  a_in_gate: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid || out_tready)
    else $error("input ready while output blocked");

  // an end marker closes its burst and carries no character
  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata[7:0] == 8'h00))
    else $error("malformed end marker");

  // end of file produces no result
  a_eof_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !out_tvalid)
    else $error("result after end of file");

  // register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind printable_run_extractor pre_chk u_pre_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);

// ===== bench/printable_run_extractor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// printable_run_extractor_tb
// Self-checking bench for the printable run extractor. Byte streams of
// printable runs, separators and end-of-file marks are sent under random
// stalls on both streams. A scan model built into the bench predicts every
// string byte and end marker, with start offsets, and each result is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
module printable_run_extractor_tb;
  import pre_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } scan_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  ch;
    logic [31:0] offset;
    logic        last;
  } str_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;    // [7:0] data_byte
  logic        in_tlast = 1'b0;     // end_of_file
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;           // [7:0] out_char, [39:8] string_offset
  logic        out_tuser;           // [0] out_kind
  logic        out_tlast;           // last_of_burst
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = 4'h0;
  logic [31:0] cfg_pwdata = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // register copies
  logic [6:0]  cfg_min = MIN_LEN_RST;
  logic        cfg_parity = PARITY_RST;
  logic [31:0] cfg_base = REGION_BASE_RST;
  logic [31:0] cfg_len = REGION_LEN_RST;

  // scan state
  logic [7:0]  held_bytes [MAX_MIN_LEN_DEF];
  int          held_cnt;
  logic        in_string;
  logic [31:0] scan_pos;
  logic [31:0] bytes_left;
  logic        scan_stopped;
  logic [31:0] run_start;

  scan_item_t  byte_q[$];
  str_result_t string_results_q[$];
  scan_item_t  drv_item;
  str_result_t want;
  str_result_t got;
  int          mismatch_cnt = 0;
  logic        steady = 1'b0;

  printable_run_extractor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // threshold as the block applies it
  function automatic int active_min();
    if (cfg_min == 7'd0) return 1;
    if (cfg_min > MAX_MIN_LEN_DEF) return MAX_MIN_LEN_DEF;
    return int'(cfg_min);
  endfunction

  function automatic void scan_restart();
    held_cnt = 0;
    in_string = 1'b0;
    scan_pos = cfg_base;
    bytes_left = cfg_len;
    scan_stopped = 1'b0;
  endfunction

  function automatic void add_string_result(logic kind, logic [7:0] ch, logic last);
    string_results_q.push_back('{kind: kind, ch: ch, offset: run_start, last: last});
  endfunction

  // advance the scan by one accepted byte
  function automatic void scan_byte(input scan_item_t it);
    logic [7:0] t;
    logic       ok;
    if (scan_stopped) return;
    if (it.eof || bytes_left == 32'd0) begin
      scan_stopped = 1'b1;
      return;
    end
    t = cfg_parity ? (it.data & ~PARITY_MASK) : it.data;
    ok = (t >= PRINT_LO) && (t <= PRINT_HI);
    if (in_string) begin
      if (ok) begin
        add_string_result(KIND_CHAR, it.data, 1'b1);
      end else begin
        add_string_result(KIND_END, 8'h00, 1'b1);
        in_string = 1'b0;
      end
    end else if (ok) begin
      if (held_cnt == 0) run_start = scan_pos;
      if (held_cnt < MAX_MIN_LEN_DEF) begin
        held_bytes[held_cnt] = it.data;
        held_cnt++;
      end
      // run long enough: release everything held
      if (held_cnt >= active_min()) begin
        for (int i = 0; i < held_cnt; i++)
          add_string_result(KIND_CHAR, held_bytes[i], i == held_cnt - 1);
        held_cnt = 0;
        in_string = 1'b1;
      end
    end else begin
      held_cnt = 0;
    end
    scan_pos = scan_pos + 32'd1;
    bytes_left = bytes_left - 32'd1;
    if (bytes_left == 32'd0) scan_stopped = 1'b1;
  endfunction

  function automatic logic [7:0] pick_printable();
    logic [7:0] b;
    b = 8'($urandom_range(PRINT_LO, PRINT_HI));
    if (cfg_parity) b[7] = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic logic [7:0] pick_noise();
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0: b = 8'($urandom_range(0, 8'h1F));
      1: b = 8'h7F;
      default: b = 8'($urandom_range(8'h80, 8'hFF));
    endcase
    if (cfg_parity) begin
      b[6:0] = ($urandom_range(0, 4) == 0) ? 7'h7F : 7'($urandom_range(0, 31));
      b[7] = 1'($urandom_range(0, 1));
    end
    return b;
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic eof);
    byte_q.push_back('{data: b, eof: eof});
  endtask

  task automatic queue_text(input string txt);
    for (int i = 0; i < txt.len(); i++) queue_byte(txt[i], 1'b0);
  endtask

  // runs around the threshold, separators and some stray noise
  task automatic make_text(input int n_active, input bit end_with_eof);
    int count;
    int len;
    count = 0;
    if (cfg_len < n_active) n_active = cfg_len;
    while (count < n_active) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_byte(pick_noise(), 1'b0);
        count++;
      end else begin
        if ($urandom_range(0, 3) == 0) len = $urandom_range(0, active_min() - 1);
        else len = $urandom_range(active_min(), active_min() + 6);
        repeat (len) queue_byte(pick_printable(), 1'b0);
        count += len;
        repeat ($urandom_range(1, 2)) begin
          queue_byte(pick_noise(), 1'b0);
          count++;
        end
      end
    end
    // stream ends with an open run possibly pending; later bytes are dropped
    if (end_with_eof) begin
      queue_byte(8'($urandom_range(0, 255)), 1'b1);
      queue_byte(pick_printable(), 1'b0);
      queue_byte(pick_printable(), 1'b0);
    end
  endtask

  // wait until every byte is taken and every result has come back
  task automatic settle();
    do @(posedge clk);
    while (byte_q.size() != 0 || in_tvalid || string_results_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // apb write: setup then access phase
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_MIN_LEN: cfg_min = val[6:0];
      REG_PARITY:  cfg_parity = val[0];
      REG_BASE: begin
        cfg_base = val;
        scan_restart();
      end
      REG_LEN: begin
        cfg_len = val;
        scan_restart();
      end
      default: ;
    endcase
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      run_start = 32'd0;
      scan_restart();
    end else begin
      if (in_tvalid && in_tready) scan_byte(drv_item);
      if (!in_tvalid || in_tready) begin
        if (byte_q.size() != 0 && (steady || $urandom_range(0, 99) >= 14)) begin
          drv_item = byte_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= drv_item.data;
          in_tlast <= drv_item.eof;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{kind: out_tuser, ch: out_tdata[7:0], offset: out_tdata[39:8], last: out_tlast};
        if (string_results_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result: kind %0d char %02h offset %08h last %0d",
                     got.kind, got.ch, got.offset, got.last);
        end else begin
          want = string_results_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: exp kind %0d char %02h offset %08h last %0d,",
                       want.kind, want.ch, want.offset, want.last,
                       " got kind %0d char %02h offset %08h last %0d",
                       got.kind, got.ch, got.offset, got.last);
          end
        end
      end
      out_tready <= steady || ($urandom_range(0, 99) >= 14);
    end
  end

  // stimulus
  initial begin
    logic [6:0]  r_min;
    logic [31:0] r_base;
    logic [31:0] r_len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: a run with burst, pass-through and end marker
    queue_text("Hello");
    queue_byte(8'h0A, 1'b0);
    settle();

    // threshold zero acts as one; printable range edges
    cfg_write(REG_MIN_LEN, 32'd0);
    queue_byte(8'h1F, 1'b0);
    queue_byte(8'h20, 1'b0);
    queue_byte(8'h7E, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    settle();

    // parity bit masked for the test only
    cfg_write(REG_PARITY, 32'd1);
    cfg_write(REG_MIN_LEN, 32'd1);
    queue_byte(8'hA0, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h9F, 1'b0);
    settle();

    // threshold lowered while a run is held
    cfg_write(REG_MIN_LEN, 32'd8);
    queue_text("abcd");
    settle();
    cfg_write(REG_MIN_LEN, 32'd2);
    queue_text("e");
    queue_byte(8'h00, 1'b0);
    settle();

    // offsets wrap, scan stops at region end
    cfg_write(REG_MIN_LEN, 32'd1);
    cfg_write(REG_BASE, 32'hFFFF_FFFF);
    cfg_write(REG_LEN, 32'd4);
    queue_byte(8'h00, 1'b0);
    queue_text("ab");
    queue_byte(8'h00, 1'b0);
    queue_text("c");
    settle();

    // empty region
    cfg_write(REG_LEN, 32'd0);
    queue_text("xy");
    settle();

    // end of file leaves the open string without marker
    cfg_write(REG_LEN, 32'hFFFF_FFFF);
    queue_text("w");
    queue_byte(8'h5A, 1'b1);
    queue_text("x");
    settle();

    // random phases, each with fresh settings
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 9))
        6: r_min = 7'd0;
        7: r_min = 7'd64;
        8: r_min = 7'd127;
        9: r_min = 7'($urandom_range(7, 20));
        default: r_min = 7'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 2))
        0: r_base = $urandom;
        1: r_base = 32'hFFFF_FFF8;
        default: r_base = $urandom_range(0, 1000);
      endcase
      case ($urandom_range(0, 5))
        0: r_len = $urandom_range(1, 40);
        1: r_len = 32'hFFFF_FFFE;
        default: r_len = 32'hFFFF_FFFF;
      endcase
      if (p == 1) r_min = 7'd127;
      if (p == 2) r_base = 32'd0;
      if (p == 5) begin
        r_min = 7'd64;
        r_base = 32'hFFFF_FFF0;
        r_len = 32'hFFFF_FFFF;
      end
      if (p == 6) r_len = 32'd1;
      steady = (p == 3 || p == 4);
      cfg_write(REG_MIN_LEN, {25'd0, r_min});
      cfg_write(REG_PARITY, (p == 2) ? 32'd0 : 32'($urandom_range(0, 1)));
      cfg_write(REG_BASE, r_base);
      cfg_write(REG_LEN, r_len);
      make_text(45, $urandom_range(0, 2) == 0);
      settle();
    end
    steady = 1'b0;

    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && string_results_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
